@@ hdl/acs_pkg.sv @@
package acs_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int ADDR_W        = 12;
    localparam int DATA_W        = 16;
    localparam logic [ADDR_W-1:0] SP_RESET = 12'hFFE;

    localparam logic [3:0] OP_JP  = 4'd0;
    localparam logic [3:0] OP_JZ  = 4'd1;
    localparam logic [3:0] OP_JN  = 4'd2;
    localparam logic [3:0] OP_LV  = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_SUB = 4'd5;
    localparam logic [3:0] OP_MUL = 4'd6;
    localparam logic [3:0] OP_DIV = 4'd7;
    localparam logic [3:0] OP_LD  = 4'd8;
    localparam logic [3:0] OP_MM  = 4'd9;
    localparam logic [3:0] OP_SC  = 4'd10;
    localparam logic [3:0] OP_RS  = 4'd11;
    localparam logic [3:0] OP_HM  = 4'd12;
    localparam logic [3:0] OP_GD  = 4'd13;
    localparam logic [3:0] OP_PD  = 4'd14;
    localparam logic [3:0] OP_OS  = 4'd15;

    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_STEP = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [7:0]        load_byte;
        logic [DATA_W-1:0] input_word;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] program_counter;
        logic [DATA_W-1:0] accumulator;
        logic              halted;
        logic              print_valid;
        logic              input_taken;
        logic              syscall_seen;
        logic              divide_fault;
    } out_word_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/acs_mem.sv @@
module acs_mem #(
    parameter int MEM_BYTES = acs_pkg::MEM_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [acs_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                wdata,
    input  logic [acs_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                rdata
);
    import acs_pkg::*;

    localparam int IDX_W = $clog2(MEM_BYTES);
    localparam int RED_W = ADDR_W + 4;

    logic [7:0] mem [MEM_BYTES];
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] ridx;

    // Reduce by compare and subtract; the quotient fits in four bits since the
    // memory holds at least a sixteenth of the address space.
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
        logic [RED_W-1:0] x;
        x = {4'b0000, a};
        for (int k = 3; k >= 0; k--) begin
            if (x >= RED_W'(MEM_BYTES << k)) begin
                x = x - RED_W'(MEM_BYTES << k);
            end
        end
        return x[ADDR_W-1:0];
    endfunction

    // address taken modulo the memory size
    assign widx = IDX_W'(wrap_addr(waddr));
    assign ridx = IDX_W'(wrap_addr(raddr));

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[widx] <= wdata;
        end
        rdata <= mem[ridx];
    end

endmodule

@@ hdl/acs_div.sv @@
module acs_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  acs_pkg::div_req_t req,
    output acs_pkg::div_rsp_t rsp
);
    import acs_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] quo_reg,  quo_next;
    logic [DATA_W-1:0] rem_reg,  rem_next;
    logic [DATA_W-1:0] den_reg,  den_next;
    logic              neg_reg,  neg_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] a_abs;
    logic [DATA_W-1:0] b_abs;

    assign a_abs = req.dividend[DATA_W-1] ? (~req.dividend + DATA_W'(1)) : req.dividend;
    assign b_abs = req.divisor[DATA_W-1]  ? (~req.divisor + DATA_W'(1))  : req.divisor;
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            quo_next  = a_abs;
            rem_next  = '0;
            den_next  = b_abs;
            neg_next  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end else if (busy_reg) begin
            // one restoring step per cycle; the remainder stays below the divisor
            if (!trial[DATA_W]) begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;

endmodule

@@ hdl/accumulator_cpu_step_unit.sv @@
// Steps from accept to result valid: a load item writes its byte, then sets up the result word;
// a step item runs fetch issue, two fetch bytes and execute; an operand word read adds the
// reads of both operand bytes, a word write adds the high-byte write, and DIV with a nonzero
// divisor adds the divider run (the quotient bits, then the done step). One item is in work at
// a time; the next is accepted in the cycle after the result word is taken.
// Reset (aresetn low, synchronous): pc and acc clear, stack pointer to 0xFFE; memory is kept.
module accumulator_cpu_step_unit #(
    parameter int MEM_BYTES = acs_pkg::MEM_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  acs_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output acs_pkg::out_word_t m_data
);
    import acs_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_LOAD  = 11'b00000000010,
        ST_F0    = 11'b00000000100,
        ST_F1    = 11'b00000001000,
        ST_F2    = 11'b00000010000,
        ST_EXEC  = 11'b00000100000,
        ST_R1    = 11'b00001000000,
        ST_R2    = 11'b00010000000,
        ST_W1    = 11'b00100000000,
        ST_DIV   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] sp_reg, sp_next;
    logic [DATA_W-1:0] ir_reg, ir_next;
    logic [7:0]        lo_reg, lo_next;
    logic [DATA_W-1:0] inw_reg, inw_next;
    out_word_t         out_reg, out_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    logic [ADDR_W-1:0] ea_reg, ea_next;
    logic [DATA_W-1:0] wv_reg, wv_next;

    div_req_t          dreq;
    div_rsp_t          drsp;

    logic [3:0]        op;
    logic [ADDR_W-1:0] pa;
    logic [DATA_W-1:0] word;
    logic [31:0]       prod;

    acs_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    acs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign op   = ir_reg[DATA_W-1 -: 4];
    assign pa   = ir_reg[ADDR_W-1:0];
    assign word = {mem_rdata, lo_reg};
    assign prod = acc_reg * word;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        acc_next   = acc_reg;
        sp_next    = sp_reg;
        ir_next    = ir_reg;
        lo_next    = lo_reg;
        inw_next   = inw_reg;
        out_next   = out_reg;
        ea_next    = ea_reg;
        wv_next    = wv_reg;
        mem_we     = 1'b0;
        mem_waddr  = s_data.address;
        mem_wdata  = s_data.load_byte;
        mem_raddr  = pc_reg;
        dreq.start    = 1'b0;
        dreq.dividend = acc_reg;
        dreq.divisor  = word;

        unique case (state_reg)
            ST_IDLE: begin
                out_next = '0;
                if (s_valid) begin
                    inw_next = s_data.input_word;
                    if (s_data.opcode == ITEM_LOAD) begin
                        mem_we     = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_F0;
                    end
                end
            end
            ST_LOAD: begin
                out_next.program_counter = pc_reg;
                out_next.accumulator     = acc_reg;
                state_next               = ST_OUT;
            end
            ST_F0: begin
                // hold the fetch address; the low byte arrives next cycle
                mem_raddr  = pc_reg;
                state_next = ST_F1;
            end
            ST_F1: begin
                lo_next    = mem_rdata;
                mem_raddr  = pc_reg + ADDR_W'(1);
                state_next = ST_F2;
            end
            ST_F2: begin
                ir_next    = word;
                pc_next    = pc_reg + ADDR_W'(2);
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_OUT;
                ea_next    = pa;
                unique case (op) inside
                    OP_JP: pc_next = pa;
                    OP_JZ: if (acc_reg == '0) pc_next = pa;
                    OP_JN: if (acc_reg[DATA_W-1]) pc_next = pa;
                    OP_LV: acc_next = {{(DATA_W-ADDR_W){1'b0}}, pa};
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LD: begin
                        mem_raddr  = pa;
                        state_next = ST_R1;
                    end
                    OP_MM: begin
                        mem_we     = 1'b1;
                        mem_waddr  = pa;
                        mem_wdata  = acc_reg[7:0];
                        wv_next    = acc_reg;
                        state_next = ST_W1;
                    end
                    OP_SC: begin
                        mem_we     = 1'b1;
                        mem_waddr  = sp_reg;
                        mem_wdata  = pc_reg[7:0];
                        wv_next    = {{(DATA_W-ADDR_W){1'b0}}, pc_reg};
                        ea_next    = sp_reg;
                        sp_next    = sp_reg - ADDR_W'(2);
                        pc_next    = pa;
                        state_next = ST_W1;
                    end
                    OP_RS: begin
                        sp_next    = sp_reg + ADDR_W'(2);
                        ea_next    = sp_reg + ADDR_W'(2);
                        mem_raddr  = sp_reg + ADDR_W'(2);
                        state_next = ST_R1;
                    end
                    OP_HM: begin
                        out_next.halted = 1'b1;
                        pc_next         = pa;
                    end
                    OP_GD: begin
                        acc_next             = inw_reg;
                        out_next.input_taken = 1'b1;
                    end
                    OP_PD: out_next.print_valid = 1'b1;
                    default: out_next.syscall_seen = 1'b1;
                endcase
                out_next.program_counter = pc_next;
                out_next.accumulator     = acc_next;
            end
            ST_R1: begin
                lo_next    = mem_rdata;
                mem_raddr  = ea_reg + ADDR_W'(1);
                state_next = ST_R2;
            end
            ST_R2: begin
                state_next = ST_OUT;
                case (op)
                    OP_ADD: acc_next = acc_reg + word;
                    OP_SUB: acc_next = acc_reg - word;
                    OP_MUL: acc_next = prod[DATA_W-1:0];
                    OP_LD:  acc_next = word;
                    OP_RS:  pc_next  = word[ADDR_W-1:0];
                    OP_DIV: begin
                        if (word == '0) begin
                            out_next.divide_fault = 1'b1;
                        end else begin
                            dreq.start = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default: ;
                endcase
                out_next.program_counter = pc_next;
                out_next.accumulator     = acc_next;
            end
            ST_W1: begin
                mem_we     = 1'b1;
                mem_waddr  = ea_reg + ADDR_W'(1);
                mem_wdata  = wv_reg[15:8];
                state_next = ST_OUT;
            end
            ST_DIV: begin
                if (drsp.done) begin
                    acc_next                 = drsp.quotient;
                    out_next.accumulator     = drsp.quotient;
                    out_next.program_counter = pc_reg;
                    state_next               = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            acc_reg   <= '0;
            sp_reg    <= SP_RESET;
            out_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            acc_reg   <= acc_next;
            sp_reg    <= sp_next;
            out_reg   <= out_next;
        end
        ir_reg  <= ir_next;
        lo_reg  <= lo_next;
        inw_reg <= inw_next;
        ea_reg  <= ea_next;
        wv_reg  <= wv_next;
    end

endmodule
